>>> hdl/jsc_pkg.sv
// Shared types, marker codes and verdict rule for the JPEG frame-header sampling checker.
// No dependencies; used by jsc_parser and jpeg_sof_sampling_checker_core.
`timescale 1ns / 1ps

package jsc_pkg;

    // Default payload capture limit (range 15 to 64)
    localparam int PAYLOAD_CAP_DEF = 32;

    // Marker codes
    localparam logic [7:0] MK_FILL = 8'hFF;
    localparam logic [7:0] MK_SOI  = 8'hD8;
    localparam logic [7:0] MK_EOI  = 8'hD9;
    localparam logic [7:0] MK_TEM  = 8'h01;
    localparam logic [7:0] MK_RST0 = 8'hD0;
    localparam logic [7:0] MK_RST7 = 8'hD7;
    localparam logic [7:0] MK_SOF0 = 8'hC0;
    localparam logic [7:0] MK_SOF1 = 8'hC1;
    localparam logic [7:0] MK_SOF2 = 8'hC2;

    // Verdict codes
    localparam logic [1:0] VD_SUPPORTED   = 2'd0;
    localparam logic [1:0] VD_UNSUPPORTED = 2'd1;
    localparam logic [1:0] VD_NO_START    = 2'd2;
    localparam logic [1:0] VD_NO_FRAME    = 2'd3;

    // Frame header payload offsets of the captured bytes
    localparam logic [15:0] IDX_COUNT = 16'd5;
    localparam logic [15:0] IDX_LUMA  = 16'd7;
    localparam logic [15:0] IDX_BLUE  = 16'd10;
    localparam logic [15:0] IDX_RED   = 16'd13;

    // Minimum lengths
    localparam logic [15:0] MIN_SEG_LEN    = 16'd2;
    localparam logic [15:0] MIN_SOF_LEN    = 16'd8;
    localparam logic [15:0] MIN_HDR_BYTES  = 16'd8;
    localparam logic [15:0] FULL_HDR_BYTES = 16'd15;

    // Sampling codes, horizontal factor high nibble, vertical low
    localparam logic [7:0] SMP_11 = 8'h11;
    localparam logic [7:0] SMP_21 = 8'h21;
    localparam logic [7:0] SMP_22 = 8'h22;

    typedef enum logic [3:0] {
        PH_SOI0,
        PH_SOI1,
        PH_SCAN,
        PH_MARK,
        PH_LEN_HI,
        PH_LEN_LO,
        PH_SOF_HI,
        PH_SOF_LO,
        PH_SKIP,
        PH_CAPTURE,
        PH_DONE
    } t_phase;

    typedef struct packed {
        logic       valid;
        logic [1:0] verdict;
        logic [7:0] count;
        logic [7:0] luma;
        logic [7:0] blue;
        logic [7:0] red;
    } t_result;

    // Verdict from the bytes captured so far
    function automatic logic [1:0] judge(
        input logic [15:0] got,
        input logic [7:0]  cnt,
        input logic [7:0]  luma,
        input logic [7:0]  blue,
        input logic [7:0]  red
    );
        logic chroma_ok;
        logic luma_ok;
        chroma_ok = (blue == SMP_11) && (red == SMP_11);
        luma_ok   = (luma == SMP_22) || (luma == SMP_21) || (luma == SMP_11);
        if (got < MIN_HDR_BYTES) begin
            return VD_NO_FRAME;
        end else if (cnt == 8'd1) begin
            return VD_SUPPORTED;
        end else if ((cnt >= 8'd3) && (got >= FULL_HDR_BYTES)) begin
            return (chroma_ok && luma_ok) ? VD_SUPPORTED : VD_UNSUPPORTED;
        end else begin
            return VD_NO_FRAME;
        end
    endfunction

endpackage

>>> hdl/jsc_parser.sv
// Marker walker and frame-header capture: per-stream state, one byte per step.
// Depends on jsc_pkg.
`timescale 1ns / 1ps

module jsc_parser #(
    parameter int PAYLOAD_CAP = jsc_pkg::PAYLOAD_CAP_DEF
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_step,
    input  logic [7:0]        i_byte,
    input  logic              i_end,
    output jsc_pkg::t_result  o_res
);

    localparam int WW = $clog2(PAYLOAD_CAP + 1);

    jsc_pkg::t_phase r_phase, n_phase;
    logic [7:0]      r_len_hi, n_len_hi;
    logic [15:0]     r_bc, n_bc;
    logic [WW-1:0]   r_wanted, n_wanted;
    logic [7:0]      r_cnt, n_cnt;
    logic [7:0]      r_luma, n_luma;
    logic [7:0]      r_blue, n_blue;
    logic [7:0]      r_red, n_red;

    logic [15:0]     seg_len;
    logic [15:0]     len_m2;
    logic [15:0]     wanted_ext;

    assign seg_len    = {r_len_hi, i_byte};
    assign len_m2     = seg_len - jsc_pkg::MIN_SEG_LEN;
    assign wanted_ext = {{(16-WW){1'b0}}, r_wanted};

    always_comb begin
        n_phase  = r_phase;
        n_len_hi = r_len_hi;
        n_bc     = r_bc;
        n_wanted = r_wanted;
        n_cnt    = r_cnt;
        n_luma   = r_luma;
        n_blue   = r_blue;
        n_red    = r_red;
        o_res    = '0;

        case (r_phase)
            jsc_pkg::PH_SOI0: begin
                if (i_byte != jsc_pkg::MK_FILL) begin
                    o_res.valid   = 1'b1;
                    o_res.verdict = jsc_pkg::VD_NO_START;
                end else begin
                    n_phase = jsc_pkg::PH_SOI1;
                end
            end
            jsc_pkg::PH_SOI1: begin
                if (i_byte != jsc_pkg::MK_SOI) begin
                    o_res.valid   = 1'b1;
                    o_res.verdict = jsc_pkg::VD_NO_START;
                end else begin
                    n_phase = jsc_pkg::PH_SCAN;
                end
            end
            jsc_pkg::PH_SCAN: begin
                if (i_byte == jsc_pkg::MK_FILL) begin
                    n_phase = jsc_pkg::PH_MARK;
                end
            end
            jsc_pkg::PH_MARK: begin
                // absorb fill bytes, pass over standalone markers
                if (i_byte == jsc_pkg::MK_FILL) begin
                    n_phase = jsc_pkg::PH_MARK;
                end else if (i_byte inside {jsc_pkg::MK_SOI, jsc_pkg::MK_EOI, jsc_pkg::MK_TEM,
                                            [jsc_pkg::MK_RST0:jsc_pkg::MK_RST7]}) begin
                    n_phase = jsc_pkg::PH_SCAN;
                end else if (i_byte inside {jsc_pkg::MK_SOF0, jsc_pkg::MK_SOF1,
                                            jsc_pkg::MK_SOF2}) begin
                    n_phase = jsc_pkg::PH_SOF_HI;
                end else begin
                    n_phase = jsc_pkg::PH_LEN_HI;
                end
            end
            jsc_pkg::PH_LEN_HI: begin
                n_len_hi = i_byte;
                n_phase  = jsc_pkg::PH_LEN_LO;
            end
            jsc_pkg::PH_SOF_HI: begin
                n_len_hi = i_byte;
                n_phase  = jsc_pkg::PH_SOF_LO;
            end
            jsc_pkg::PH_LEN_LO: begin
                if (seg_len < jsc_pkg::MIN_SEG_LEN) begin
                    o_res.valid   = 1'b1;
                    o_res.verdict = jsc_pkg::VD_NO_FRAME;
                end else begin
                    n_bc    = len_m2;
                    n_phase = (len_m2 == 16'd0) ? jsc_pkg::PH_SCAN : jsc_pkg::PH_SKIP;
                end
            end
            jsc_pkg::PH_SOF_LO: begin
                if (seg_len < jsc_pkg::MIN_SOF_LEN) begin
                    o_res.valid   = 1'b1;
                    o_res.verdict = jsc_pkg::VD_NO_FRAME;
                end else begin
                    n_wanted = (len_m2 > 16'(PAYLOAD_CAP)) ? WW'(PAYLOAD_CAP) : len_m2[WW-1:0];
                    n_bc     = 16'd0;
                    n_phase  = jsc_pkg::PH_CAPTURE;
                end
            end
            jsc_pkg::PH_SKIP: begin
                n_bc = r_bc - 16'd1;
                if (n_bc == 16'd0) begin
                    n_phase = jsc_pkg::PH_SCAN;
                end
            end
            jsc_pkg::PH_CAPTURE: begin
                if (r_bc == jsc_pkg::IDX_COUNT) begin
                    n_cnt = i_byte;
                end else if (r_bc == jsc_pkg::IDX_LUMA) begin
                    n_luma = i_byte;
                end else if (r_bc == jsc_pkg::IDX_BLUE) begin
                    n_blue = i_byte;
                end else if (r_bc == jsc_pkg::IDX_RED) begin
                    n_red = i_byte;
                end
                n_bc = r_bc + 16'd1;
                if (n_bc >= wanted_ext) begin
                    o_res.valid   = 1'b1;
                    o_res.verdict = jsc_pkg::judge(n_bc, n_cnt, n_luma, n_blue, n_red);
                end
            end
            jsc_pkg::PH_DONE: begin
                n_phase = jsc_pkg::PH_DONE;
            end
            default: begin
                n_phase = jsc_pkg::PH_DONE;
            end
        endcase

        // end of stream with no verdict yet: decide from where the walk stands
        if (!o_res.valid && i_end && (r_phase != jsc_pkg::PH_DONE)) begin
            o_res.valid = 1'b1;
            if ((n_phase == jsc_pkg::PH_SOI0) || (n_phase == jsc_pkg::PH_SOI1)) begin
                o_res.verdict = jsc_pkg::VD_NO_START;
            end else if (n_phase == jsc_pkg::PH_CAPTURE) begin
                o_res.verdict = jsc_pkg::judge(n_bc, n_cnt, n_luma, n_blue, n_red);
            end else begin
                o_res.verdict = jsc_pkg::VD_NO_FRAME;
            end
        end

        if (o_res.valid) begin
            n_phase = jsc_pkg::PH_DONE;
            if (o_res.verdict != jsc_pkg::VD_NO_START) begin
                o_res.count = n_cnt;
                o_res.luma  = n_luma;
                o_res.blue  = n_blue;
                o_res.red   = n_red;
            end
        end

        // rearm for the next stream
        if (i_end) begin
            n_phase  = jsc_pkg::PH_SOI0;
            n_len_hi = 8'd0;
            n_bc     = 16'd0;
            n_wanted = '0;
            n_cnt    = 8'd0;
            n_luma   = 8'd0;
            n_blue   = 8'd0;
            n_red    = 8'd0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase  <= jsc_pkg::PH_SOI0;
            r_len_hi <= 8'd0;
            r_bc     <= 16'd0;
            r_wanted <= '0;
            r_cnt    <= 8'd0;
            r_luma   <= 8'd0;
            r_blue   <= 8'd0;
            r_red    <= 8'd0;
        end else if (i_step) begin
            r_phase  <= n_phase;
            r_len_hi <= n_len_hi;
            r_bc     <= n_bc;
            r_wanted <= n_wanted;
            r_cnt    <= n_cnt;
            r_luma   <= n_luma;
            r_blue   <= n_blue;
            r_red    <= n_red;
        end
    end

endmodule

>>> hdl/jpeg_sof_sampling_checker_core.sv
// JPEG frame-header sampling checker, top level: input register, parser, result register.
// Depends on jsc_pkg and jsc_parser.
`timescale 1ns / 1ps

// Usage
//   Input channel: one stream byte per item (i_data_byte) with i_stream_end set on the
//   last byte of a stream. An item is taken at an edge with i_valid high and o_stall low.
//   Output channel: one verdict item per stream, with the captured component count and
//   the three sampling bytes. The receiver takes it at an edge with o_valid high and
//   i_stall low.
//   Throughput: one byte per cycle, sustained, while results are taken. The limit is the
//   state update of the marker walker, one byte per step; a byte passes into the input
//   register and then through the walker into the result register, which drives the
//   output ports.
//   Stall: while a verdict waits on a stalled receiver, the walker holds every byte,
//   verdict or not. An empty input register still takes one byte; once it is full,
//   o_stall stays high until the verdict is taken.
//   Reset: synchronous, active low; clears the walker to expect a start marker and
//   empties both registers. No clearing pass is needed.
//   After a verdict, further bytes of the stream are dropped until i_stream_end rearms.
module jpeg_sof_sampling_checker_core #(
    parameter int PAYLOAD_CAP = jsc_pkg::PAYLOAD_CAP_DEF
) (
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_valid,
    output logic       o_stall,
    input  logic [7:0] i_data_byte,
    input  logic       i_stream_end,
    output logic       o_valid,
    input  logic       i_stall,
    output logic [1:0] o_verdict,
    output logic [7:0] o_component_count,
    output logic [7:0] o_luma_sampling,
    output logic [7:0] o_blue_chroma_sampling,
    output logic [7:0] o_red_chroma_sampling
);

    // input register
    logic       r_in_valid, n_in_valid;
    logic [7:0] r_in_byte;
    logic       r_in_end;

    // result register
    logic       r_out_valid, n_out_valid;
    logic [1:0] r_verdict;
    logic [7:0] r_count;
    logic [7:0] r_luma;
    logic [7:0] r_blue;
    logic [7:0] r_red;

    logic             advance;
    logic             step;
    logic             take_in;
    jsc_pkg::t_result res;

    // The walker may move whenever the result slot is free or being emptied
    assign advance = !r_out_valid || !i_stall;
    assign step    = r_in_valid && advance;
    assign o_stall = r_in_valid && !advance;
    assign take_in = i_valid && !o_stall;

    jsc_parser #(
        .PAYLOAD_CAP (PAYLOAD_CAP)
    ) u_parser (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_step  (step),
        .i_byte  (r_in_byte),
        .i_end   (r_in_end),
        .o_res   (res)
    );

    always_comb begin
        n_in_valid  = take_in || (r_in_valid && !step);
        n_out_valid = (r_out_valid && i_stall) || (step && res.valid);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid  <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            r_in_valid  <= n_in_valid;
            r_out_valid <= n_out_valid;
        end
    end

    // Payload registers: load on accept, hold otherwise
    always_ff @(posedge i_clk) begin
        if (take_in) begin
            r_in_byte <= i_data_byte;
            r_in_end  <= i_stream_end;
        end
        if (step && res.valid) begin
            r_verdict <= res.verdict;
            r_count   <= res.count;
            r_luma    <= res.luma;
            r_blue    <= res.blue;
            r_red     <= res.red;
        end
    end

    assign o_valid                = r_out_valid;
    assign o_verdict              = r_verdict;
    assign o_component_count      = r_count;
    assign o_luma_sampling        = r_luma;
    assign o_blue_chroma_sampling = r_blue;
    assign o_red_chroma_sampling  = r_red;

`ifndef SYNTHESIS
    // A missing start marker carries no captured bytes
    a_no_start_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && (o_verdict == jsc_pkg::VD_NO_START)) |->
        ((o_component_count == 8'd0) && (o_luma_sampling == 8'd0) &&
         (o_blue_chroma_sampling == 8'd0) && (o_red_chroma_sampling == 8'd0)))
        else $error("no-start verdict with non-zero capture fields");

    // Supported only for grayscale or three or more components
    a_supported_count: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && (o_verdict == jsc_pkg::VD_SUPPORTED)) |->
        ((o_component_count == 8'd1) || (o_component_count >= 8'd3)))
        else $error("supported verdict with impossible component count");

    // A fresh result must come from a byte that was waiting in the input register
    a_result_from_item: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && !$past(o_valid)) |-> $past(r_in_valid))
        else $error("result appeared without a pending item");
`endif

endmodule

>>> tb/jpeg_sof_sampling_checker_core_test.sv
// Self-checking testbench for jpeg_sof_sampling_checker_core: directed byte table, then random
// JPEG-like streams; verdicts checked against typed rows or a local marker-walker model.
// Depends on jsc_pkg and the checker RTL only.
`timescale 1ns / 1ps

module jpeg_sof_sampling_checker_core_test;

    localparam int CAPTURE_LIMIT = jsc_pkg::PAYLOAD_CAP_DEF;
    localparam int TARGET_ITEMS  = 1200;
    localparam int TARGET_STREAMS = 48;
    localparam int IDLE_LIMIT    = 5000;   // cycles with no item moving on either side
    localparam int DRAIN_CYCLES  = 8;      // input register plus walker, with margin
    localparam int HOLD_CYCLES   = 400;    // long receiver hold-off
    localparam int HOLD_PHASE    = 6;

    typedef struct packed {
        logic [1:0] verdict;
        logic [7:0] count;
        logic [7:0] luma;
        logic [7:0] blue;
        logic [7:0] red;
    } t_verdict;

    typedef enum logic {ROW_PREDICT, ROW_TYPED} t_row_kind;

    typedef struct packed {
        logic [7:0] data;
        logic       last;
        t_row_kind  kind;
        t_verdict   want;
    } t_stim_row;

    typedef enum logic [1:0] {RX_FREE, RX_LIGHT, RX_HEAVY, RX_TOGGLE} t_rx_mode;

    localparam t_verdict NO_VERDICT    = '0;
    localparam t_verdict START_MISSING = '{jsc_pkg::VD_NO_START, 8'h00, 8'h00, 8'h00, 8'h00};
    localparam t_verdict FRAME_MISSING = '{jsc_pkg::VD_NO_FRAME, 8'h00, 8'h00, 8'h00, 8'h00};

    localparam int DIRECTED_ROWS = 35;

    // Short directed streams: bad start, end inside the start marker, fill bytes and a stuffed
    // code with a too-short length, a too-short frame header, end while scanning, and a frame
    // header whose capture completes before the end flag (the trailing byte must be dropped).
    t_stim_row directed_rows [DIRECTED_ROWS] = '{
        '{8'h00,            1'b1, ROW_TYPED,   START_MISSING},
        '{jsc_pkg::MK_FILL, 1'b1, ROW_TYPED,   START_MISSING},
        '{jsc_pkg::MK_FILL, 1'b0, ROW_PREDICT, NO_VERDICT},
        '{jsc_pkg::MK_SOI,  1'b0, ROW_PREDICT, NO_VERDICT},
        '{jsc_pkg::MK_FILL, 1'b0, ROW_PREDICT, NO_VERDICT},
        '{jsc_pkg::MK_TEM,  1'b0, ROW_PREDICT, NO_VERDICT},
        '{jsc_pkg::MK_FILL, 1'b0, ROW_PREDICT, NO_VERDICT},
        '{jsc_pkg::MK_FILL, 1'b0, ROW_PREDICT, NO_VERDICT},
        '{8'h00,            1'b0, ROW_PREDICT, NO_VERDICT},
        '{8'h00,            1'b0, ROW_PREDICT, NO_VERDICT},
        '{8'h01,            1'b1, ROW_TYPED,   FRAME_MISSING},
        '{jsc_pkg::MK_FILL, 1'b0, ROW_PREDICT, NO_VERDICT},
        '{jsc_pkg::MK_SOI,  1'b0, ROW_PREDICT, NO_VERDICT},
        '{jsc_pkg::MK_FILL, 1'b0, ROW_PREDICT, NO_VERDICT},
        '{jsc_pkg::MK_SOF0, 1'b0, ROW_PREDICT, NO_VERDICT},
        '{8'h00,            1'b0, ROW_PREDICT, NO_VERDICT},
        '{8'h07,            1'b1, ROW_TYPED,   FRAME_MISSING},
        '{jsc_pkg::MK_FILL, 1'b0, ROW_PREDICT, NO_VERDICT},
        '{jsc_pkg::MK_SOI,  1'b0, ROW_PREDICT, NO_VERDICT},
        '{jsc_pkg::MK_EOI,  1'b1, ROW_TYPED,   FRAME_MISSING},
        '{jsc_pkg::MK_FILL, 1'b0, ROW_PREDICT, NO_VERDICT},
        '{jsc_pkg::MK_SOI,  1'b0, ROW_PREDICT, NO_VERDICT},
        '{jsc_pkg::MK_FILL, 1'b0, ROW_PREDICT, NO_VERDICT},
        '{jsc_pkg::MK_SOF2, 1'b0, ROW_PREDICT, NO_VERDICT},
        '{8'h00,            1'b0, ROW_PREDICT, NO_VERDICT},
        '{8'h0A,            1'b0, ROW_PREDICT, NO_VERDICT},
        '{8'h08,            1'b0, ROW_PREDICT, NO_VERDICT},
        '{8'h00,            1'b0, ROW_PREDICT, NO_VERDICT},
        '{8'h10,            1'b0, ROW_PREDICT, NO_VERDICT},
        '{8'h00,            1'b0, ROW_PREDICT, NO_VERDICT},
        '{8'h10,            1'b0, ROW_PREDICT, NO_VERDICT},
        '{8'h01,            1'b0, ROW_PREDICT, NO_VERDICT},
        '{8'h00,            1'b0, ROW_PREDICT, NO_VERDICT},
        '{jsc_pkg::SMP_22,  1'b0, ROW_TYPED,
          '{jsc_pkg::VD_SUPPORTED, 8'h01, jsc_pkg::SMP_22, 8'h00, 8'h00}},
        '{jsc_pkg::MK_FILL, 1'b1, ROW_PREDICT, NO_VERDICT}
    };

    logic       i_clk        = 1'b0;
    logic       i_rst_n      = 1'b0;
    logic       i_valid      = 1'b0;
    logic [7:0] i_data_byte  = 8'h00;
    logic       i_stream_end = 1'b0;
    logic       i_stall      = 1'b0;
    logic       o_stall;
    logic       o_valid;
    logic [1:0] o_verdict;
    logic [7:0] o_component_count;
    logic [7:0] o_luma_sampling;
    logic [7:0] o_blue_chroma_sampling;
    logic [7:0] o_red_chroma_sampling;

    // Per-item tag travelling with the payload, so the checker knows a typed row
    t_row_kind  row_kind    = ROW_PREDICT;
    t_verdict   row_verdict = NO_VERDICT;

    t_verdict   verdicts_due [$];
    logic [7:0] stream_bytes [$];
    int         fail_count   = 0;
    int         idle_cycles  = 0;
    int         items_sent   = 0;
    int         burst_left   = 0;

    // Local copy of the marker walker state
    jsc_pkg::t_phase walk_phase;
    logic [15:0] walk_len;
    logic [15:0] walk_count;
    logic [6:0]  walk_wanted;
    logic [7:0]  held_count;
    logic [7:0]  held_luma;
    logic [7:0]  held_blue;
    logic [7:0]  held_red;
    logic        walk_decided;

    always begin
        #2 i_clk = 1'b1;
        #2 i_clk = 1'b0;
    end

    jpeg_sof_sampling_checker_core #(
        .PAYLOAD_CAP (CAPTURE_LIMIT)
    ) uut (
        .i_clk                  (i_clk),
        .i_rst_n                (i_rst_n),
        .i_valid                (i_valid),
        .o_stall                (o_stall),
        .i_data_byte            (i_data_byte),
        .i_stream_end           (i_stream_end),
        .o_valid                (o_valid),
        .i_stall                (i_stall),
        .o_verdict              (o_verdict),
        .o_component_count      (o_component_count),
        .o_luma_sampling        (o_luma_sampling),
        .o_blue_chroma_sampling (o_blue_chroma_sampling),
        .o_red_chroma_sampling  (o_red_chroma_sampling)
    );

    function automatic bit is_standalone(input logic [7:0] code);
        return code == jsc_pkg::MK_SOI || code == jsc_pkg::MK_EOI || code == jsc_pkg::MK_TEM ||
               (code >= jsc_pkg::MK_RST0 && code <= jsc_pkg::MK_RST7);
    endfunction

    function automatic bit is_frame_start(input logic [7:0] code);
        return code == jsc_pkg::MK_SOF0 || code == jsc_pkg::MK_SOF1 || code == jsc_pkg::MK_SOF2;
    endfunction

    function automatic void clear_walker();
        walk_phase   = jsc_pkg::PH_SOI0;
        walk_len     = '0;
        walk_count   = '0;
        walk_wanted  = '0;
        held_count   = '0;
        held_luma    = '0;
        held_blue    = '0;
        held_red     = '0;
        walk_decided = 1'b0;
    endfunction

    // Grade the frame header from the bytes captured so far
    function automatic logic [1:0] rate_frame(input logic [15:0] got);
        logic chroma_ok;
        logic luma_ok;
        chroma_ok = held_blue == jsc_pkg::SMP_11 && held_red == jsc_pkg::SMP_11;
        luma_ok   = held_luma == jsc_pkg::SMP_22 || held_luma == jsc_pkg::SMP_21 ||
                    held_luma == jsc_pkg::SMP_11;
        if (got < jsc_pkg::MIN_HDR_BYTES) begin
            return jsc_pkg::VD_NO_FRAME;
        end
        if (held_count == 8'd1) begin
            return jsc_pkg::VD_SUPPORTED;
        end
        if (held_count >= 8'd3 && got >= jsc_pkg::FULL_HDR_BYTES) begin
            return (chroma_ok && luma_ok) ? jsc_pkg::VD_SUPPORTED : jsc_pkg::VD_UNSUPPORTED;
        end
        return jsc_pkg::VD_NO_FRAME;
    endfunction

    // Advance the walker by one byte; return 1 with the verdict when this byte decides the stream
    function automatic bit walk_byte(input logic [7:0] data, input logic last,
                                     output t_verdict result);
        bit         decided;
        logic [1:0] code;
        logic [15:0] room;
        decided = 1'b0;
        code    = jsc_pkg::VD_NO_FRAME;
        result  = NO_VERDICT;
        if (!walk_decided) begin
            case (walk_phase)
                jsc_pkg::PH_SOI0: begin
                    if (data != jsc_pkg::MK_FILL) begin
                        decided = 1'b1;
                        code    = jsc_pkg::VD_NO_START;
                    end else begin
                        walk_phase = jsc_pkg::PH_SOI1;
                    end
                end
                jsc_pkg::PH_SOI1: begin
                    if (data != jsc_pkg::MK_SOI) begin
                        decided = 1'b1;
                        code    = jsc_pkg::VD_NO_START;
                    end else begin
                        walk_phase = jsc_pkg::PH_SCAN;
                    end
                end
                jsc_pkg::PH_SCAN: begin
                    if (data == jsc_pkg::MK_FILL) walk_phase = jsc_pkg::PH_MARK;
                end
                jsc_pkg::PH_MARK: begin
                    if (data == jsc_pkg::MK_FILL) begin
                        walk_phase = jsc_pkg::PH_MARK;
                    end else if (is_standalone(data)) begin
                        walk_phase = jsc_pkg::PH_SCAN;
                    end else if (is_frame_start(data)) begin
                        walk_phase = jsc_pkg::PH_SOF_HI;
                    end else begin
                        walk_phase = jsc_pkg::PH_LEN_HI;
                    end
                end
                jsc_pkg::PH_LEN_HI, jsc_pkg::PH_SOF_HI: begin
                    walk_len = {data, 8'h00};
                    if (walk_phase == jsc_pkg::PH_LEN_HI) walk_phase = jsc_pkg::PH_LEN_LO;
                    else walk_phase = jsc_pkg::PH_SOF_LO;
                end
                jsc_pkg::PH_LEN_LO: begin
                    walk_len[7:0] = data;
                    if (walk_len < jsc_pkg::MIN_SEG_LEN) begin
                        decided = 1'b1;
                    end else begin
                        walk_count = walk_len - 16'd2;
                        if (walk_count == 16'd0) walk_phase = jsc_pkg::PH_SCAN;
                        else walk_phase = jsc_pkg::PH_SKIP;
                    end
                end
                jsc_pkg::PH_SOF_LO: begin
                    walk_len[7:0] = data;
                    if (walk_len < jsc_pkg::MIN_SOF_LEN) begin
                        decided = 1'b1;
                    end else begin
                        room        = walk_len - 16'd2;
                        walk_wanted = (room > CAPTURE_LIMIT) ? 7'(CAPTURE_LIMIT) : room[6:0];
                        walk_count  = '0;
                        walk_phase  = jsc_pkg::PH_CAPTURE;
                    end
                end
                jsc_pkg::PH_SKIP: begin
                    walk_count = walk_count - 16'd1;
                    if (walk_count == 16'd0) walk_phase = jsc_pkg::PH_SCAN;
                end
                jsc_pkg::PH_CAPTURE: begin
                    if (walk_count == jsc_pkg::IDX_COUNT) held_count = data;
                    else if (walk_count == jsc_pkg::IDX_LUMA) held_luma = data;
                    else if (walk_count == jsc_pkg::IDX_BLUE) held_blue = data;
                    else if (walk_count == jsc_pkg::IDX_RED) held_red = data;
                    walk_count = walk_count + 16'd1;
                    if (walk_count >= 16'(walk_wanted)) begin
                        decided = 1'b1;
                        code    = rate_frame(walk_count);
                    end
                end
                default: ;
            endcase
            // End flag before a verdict: grade what we have
            if (!decided && last) begin
                decided = 1'b1;
                if (walk_phase == jsc_pkg::PH_SOI0 || walk_phase == jsc_pkg::PH_SOI1) begin
                    code = jsc_pkg::VD_NO_START;
                end else if (walk_phase == jsc_pkg::PH_CAPTURE) begin
                    code = rate_frame(walk_count);
                end else begin
                    code = jsc_pkg::VD_NO_FRAME;
                end
            end
        end
        if (decided) begin
            result.verdict = code;
            if (code != jsc_pkg::VD_NO_START) begin
                result.count = held_count;
                result.luma  = held_luma;
                result.blue  = held_blue;
                result.red   = held_red;
            end
            walk_decided = 1'b1;
            walk_phase   = jsc_pkg::PH_DONE;
        end
        if (last) clear_walker();
        return decided;
    endfunction

    function automatic void check_field(input string field, input logic [7:0] want,
                                        input logic [7:0] got);
        if (got !== want) begin
            $error("%s: expected %0h, got %0h", field, want, got);
            fail_count++;
        end
    endfunction

    // Offer one item; gaps come between bursts, payload holds while stalled
    task automatic offer_item(input logic [7:0] data, input logic last,
                              input t_row_kind kind, input t_verdict want);
        int gap;
        if (burst_left == 0) begin
            burst_left = $urandom_range(1, 40);
            gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 8);
            if (gap != 0) begin
                i_valid <= 1'b0;
                repeat (gap) @(posedge i_clk);
            end
        end
        burst_left--;
        i_valid      <= 1'b1;
        i_data_byte  <= data;
        i_stream_end <= last;
        row_kind     <= kind;
        row_verdict  <= want;
        @(posedge i_clk);
        while (o_stall) @(posedge i_clk);
        items_sent++;
    endtask

    // Drop valid and wait until every pending verdict has been taken
    task automatic wait_for_verdicts();
        i_valid <= 1'b0;
        do @(posedge i_clk); while (verdicts_due.size() != 0);
    endtask

    // Build one random stream: mostly well formed, the rest bad starts and marker noise
    task automatic build_stream();
        int         pick;
        int         seg_len;
        int         cut;
        logic [7:0] code;
        logic [7:0] payload [$];
        stream_bytes.delete();
        payload.delete();
        pick = $urandom_range(0, 9);
        if (pick == 9) begin
            stream_bytes.push_back($urandom_range(0, 1) ? jsc_pkg::MK_FILL :
                                   8'($urandom_range(0, 255)));
            repeat ($urandom_range(0, 4)) stream_bytes.push_back(8'($urandom_range(0, 255)));
        end else if (pick == 8) begin
            stream_bytes.push_back(jsc_pkg::MK_FILL);
            stream_bytes.push_back(jsc_pkg::MK_SOI);
            repeat ($urandom_range(1, 40)) begin
                stream_bytes.push_back(($urandom_range(0, 3) == 0) ? jsc_pkg::MK_FILL :
                                       8'($urandom_range(0, 255)));
            end
        end else begin
            stream_bytes.push_back(jsc_pkg::MK_FILL);
            stream_bytes.push_back(jsc_pkg::MK_SOI);
            // Leading segments before the frame header
            repeat ($urandom_range(0, 3)) begin
                case ($urandom_range(0, 5))
                    0: begin
                        stream_bytes.push_back(jsc_pkg::MK_FILL);
                        case ($urandom_range(0, 3))
                            0: code = jsc_pkg::MK_TEM;
                            1: code = jsc_pkg::MK_SOI;
                            2: code = jsc_pkg::MK_EOI;
                            default: code = 8'(jsc_pkg::MK_RST0 + $urandom_range(0, 7));
                        endcase
                        stream_bytes.push_back(code);
                    end
                    1: begin
                        repeat ($urandom_range(1, 4)) begin
                            stream_bytes.push_back(8'($urandom_range(0, 254)));
                        end
                    end
                    default: begin
                        repeat ($urandom_range(1, 3)) stream_bytes.push_back(jsc_pkg::MK_FILL);
                        do code = 8'($urandom_range(0, 255));
                        while (code == jsc_pkg::MK_FILL || is_standalone(code) ||
                               is_frame_start(code));
                        stream_bytes.push_back(code);
                        seg_len = ($urandom_range(0, 15) == 0) ? $urandom_range(0, 1) :
                                                                 $urandom_range(2, 24);
                        stream_bytes.push_back(8'(seg_len >> 8));
                        stream_bytes.push_back(8'(seg_len));
                        repeat ((seg_len >= 2) ? seg_len - 2 : 0) begin
                            stream_bytes.push_back(8'($urandom_range(0, 255)));
                        end
                    end
                endcase
            end
            // Frame header, with lengths around the capture limit and a few too short
            repeat ($urandom_range(1, 2)) stream_bytes.push_back(jsc_pkg::MK_FILL);
            stream_bytes.push_back(8'(jsc_pkg::MK_SOF0 + $urandom_range(0, 2)));
            case ($urandom_range(0, 7))
                4: seg_len = 11;
                5: seg_len = $urandom_range(8, 16);
                6: seg_len = $urandom_range(CAPTURE_LIMIT + 2, CAPTURE_LIMIT + 8);
                7: seg_len = $urandom_range(0, 7);
                default: seg_len = 17;
            endcase
            stream_bytes.push_back(8'(seg_len >> 8));
            stream_bytes.push_back(8'(seg_len));
            repeat ((seg_len >= 2) ? seg_len - 2 : 0) payload.push_back(8'($urandom_range(0, 255)));
            if (payload.size() > jsc_pkg::IDX_COUNT) begin
                case ($urandom_range(0, 7))
                    0: payload[jsc_pkg::IDX_COUNT] = 8'd1;
                    4: payload[jsc_pkg::IDX_COUNT] = 8'd2;
                    5: payload[jsc_pkg::IDX_COUNT] = 8'd0;
                    6: payload[jsc_pkg::IDX_COUNT] = 8'd4;
                    7: payload[jsc_pkg::IDX_COUNT] = 8'($urandom_range(0, 255));
                    default: payload[jsc_pkg::IDX_COUNT] = 8'd3;
                endcase
            end
            if (payload.size() > jsc_pkg::IDX_LUMA) begin
                case ($urandom_range(0, 4))
                    0: payload[jsc_pkg::IDX_LUMA] = jsc_pkg::SMP_11;
                    1: payload[jsc_pkg::IDX_LUMA] = jsc_pkg::SMP_21;
                    2: payload[jsc_pkg::IDX_LUMA] = jsc_pkg::SMP_22;
                    default: payload[jsc_pkg::IDX_LUMA] = 8'($urandom_range(0, 255));
                endcase
            end
            if (payload.size() > jsc_pkg::IDX_BLUE && $urandom_range(0, 3) != 0) begin
                payload[jsc_pkg::IDX_BLUE] = jsc_pkg::SMP_11;
            end
            if (payload.size() > jsc_pkg::IDX_RED && $urandom_range(0, 3) != 0) begin
                payload[jsc_pkg::IDX_RED] = jsc_pkg::SMP_11;
            end
            foreach (payload[i]) stream_bytes.push_back(payload[i]);
            // Trailing bytes after the verdict are to be dropped
            repeat ($urandom_range(0, 4)) stream_bytes.push_back(8'($urandom_range(0, 255)));
        end
        // Cut some streams short so the end flag lands mid-segment or mid-capture
        if ($urandom_range(0, 5) == 0) begin
            cut = $urandom_range(1, stream_bytes.size());
            while (stream_bytes.size() > cut) void'(stream_bytes.pop_back());
        end
    endtask

    // Track both handshakes at the edge: predict on input items, compare on output items
    always @(posedge i_clk) begin : verdict_tracking
        t_verdict calc;
        t_verdict got;
        t_verdict want;
        bit       moved;
        moved = 1'b0;
        if (i_rst_n) begin
            if (i_valid && !o_stall) begin
                moved = 1'b1;
                if (walk_byte(i_data_byte, i_stream_end, calc) && row_kind == ROW_PREDICT) begin
                    verdicts_due.push_back(calc);
                end
                if (row_kind == ROW_TYPED) verdicts_due.push_back(row_verdict);
            end
            if (o_valid && !i_stall) begin
                moved = 1'b1;
                got = '{o_verdict, o_component_count, o_luma_sampling,
                        o_blue_chroma_sampling, o_red_chroma_sampling};
                if (verdicts_due.size() == 0) begin
                    $error("unexpected verdict item: verdict %0d", got.verdict);
                    fail_count++;
                end else begin
                    want = verdicts_due.pop_front();
                    check_field("verdict", 8'(want.verdict), 8'(got.verdict));
                    check_field("component_count", want.count, got.count);
                    check_field("luma_sampling", want.luma, got.luma);
                    check_field("blue_chroma_sampling", want.blue, got.blue);
                    check_field("red_chroma_sampling", want.red, got.red);
                end
            end
        end
        idle_cycles = moved ? 0 : idle_cycles + 1;
    end

    // Receiver: phases of free running, light, heavy and alternating stall, plus one long hold
    initial begin : receiver_stall
        t_rx_mode mode;
        int       phase;
        int       span;
        int       step;
        wait (i_rst_n);
        @(posedge i_clk);
        phase = 0;
        forever begin
            if (phase == HOLD_PHASE) begin
                i_stall <= 1'b1;
                repeat (HOLD_CYCLES) @(posedge i_clk);
            end else begin
                mode = t_rx_mode'($urandom_range(0, 3));
                span = $urandom_range(10, 150);
                for (step = 0; step < span; step++) begin
                    case (mode)
                        RX_FREE:   i_stall <= 1'b0;
                        RX_LIGHT:  i_stall <= ($urandom_range(0, 3) == 0);
                        RX_HEAVY:  i_stall <= ($urandom_range(0, 3) != 0);
                        RX_TOGGLE: i_stall <= step[0];
                        default:   i_stall <= 1'b0;
                    endcase
                    @(posedge i_clk);
                end
            end
            phase++;
        end
    end

    // Stop the run if nothing moves for too long
    initial begin : idle_watchdog
        wait (idle_cycles >= IDLE_LIMIT);
        $display("[FAIL] regression broken");
        $finish;
    end

    initial begin : stimulus
        int streams_sent;
        clear_walker();
        repeat (3) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        foreach (directed_rows[r]) begin
            offer_item(directed_rows[r].data, directed_rows[r].last,
                       directed_rows[r].kind, directed_rows[r].want);
        end

        streams_sent = 0;
        while (items_sent < TARGET_ITEMS || streams_sent < TARGET_STREAMS) begin
            build_stream();
            // Pause now and then until the block has handed over every verdict
            if (streams_sent == 5 || $urandom_range(0, 9) == 0) wait_for_verdicts();
            foreach (stream_bytes[i]) begin
                offer_item(stream_bytes[i], i == stream_bytes.size() - 1, ROW_PREDICT, NO_VERDICT);
            end
            streams_sent++;
        end

        wait_for_verdicts();
        repeat (DRAIN_CYCLES) @(posedge i_clk);
        if (fail_count == 0) begin
            $display("[ OK ] regression clean");
        end else begin
            $display("[FAIL] regression broken");
        end
        $finish;
    end

endmodule

>>> jpeg_sof_sampling_checker_core.f
hdl/jsc_pkg.sv
hdl/jsc_parser.sv
hdl/jpeg_sof_sampling_checker_core.sv
tb/jpeg_sof_sampling_checker_core_test.sv
